### hdl/spd_pkg.sv
// Package for the serial packet deframer: frame constants, request and status codes.
// No dependencies. Used by serial_packet_deframer_unit.
package spd_pkg;

    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int HEADER_BYTES     = 10;
    localparam int MIN_FRAME        = 11;

    localparam logic [7:0] SYNC_FIRST  = 8'h44;
    localparam logic [7:0] SYNC_SECOND = 8'h4B;

    // header byte positions in the frame store
    localparam int POS_LEN_LO  = 2;
    localparam int POS_LEN_HI  = 3;
    localparam int POS_DEST    = 4;
    localparam int POS_SRC     = 5;
    localparam int POS_MSG     = 6;
    localparam int POS_REF     = 7;
    localparam int POS_TYPE_LO = 8;
    localparam int POS_TYPE_HI = 9;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_GOOD    = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_READ    = 2'd3
    } t_status;

endpackage

### hdl/spd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/serial_packet_deframer_unit.sv
// Serial packet deframer top level: sync hunt, header parse, running checksum,
// millisecond timeout and payload read-back. Depends on spd_pkg and spd_ram.
//
//  channel   direction  handshake                    payload
//  request   in         i_in_valid / o_in_ready      i_req_type, i_rx_byte, i_payload_index
//  result    out        o_out_valid / i_out_ready    o_status .. o_payload_byte
//  config    in         i_cfg_valid / o_cfg_ready    i_cfg_response_timeout_ms
//
// One request per cycle while the output is not stalled; each request gives one result,
// registered in the parse stage and then in the output register. The frame store is a RAM
// with registered read data; a read request's byte is taken from it on the way to the output.
// Reset is synchronous; the frame store is not cleared (no clearing pass).
// An output stall backs up through the parse stage and then drops o_in_ready.
// o_in_ready and o_cfg_ready are low during reset; o_cfg_ready is high otherwise.
module serial_packet_deframer_unit #(
    parameter int BUFFER_BYTES = spd_pkg::BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic [9:0]  i_payload_index,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_dest_address,
    output logic [7:0]  o_src_address,
    output logic [7:0]  o_message_number,
    output logic [7:0]  o_reference_number,
    output logic [15:0] o_packet_type,
    output logic [9:0]  o_payload_length,
    output logic [7:0]  o_payload_byte,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_response_timeout_ms
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = AW + 1;
    localparam int PW = (AW + 1 > 11) ? AW + 1 : 11;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CHECK
    } t_phase;

    // parser / control state
    t_phase         r_phase, n_phase;
    logic           r_listening, n_listening;
    logic [CW-1:0]  r_bytes_stored, n_bytes_stored;
    logic [CW-1:0]  r_bytes_remaining, n_bytes_remaining;
    logic [7:0]     r_sum, n_sum;
    logic [31:0]    r_elapsed, n_elapsed;
    logic [31:0]    r_timeout;

    // header shadow copies of store bytes 2..9
    logic [7:0]     r_len_lo, n_len_lo;
    logic [7:0]     r_len_hi, n_len_hi;
    logic [7:0]     r_dest, n_dest;
    logic [7:0]     r_src, n_src;
    logic [7:0]     r_msg, n_msg;
    logic [7:0]     r_ref, n_ref;
    logic [7:0]     r_type_lo, n_type_lo;
    logic [7:0]     r_type_hi, n_type_hi;

    // parse stage
    logic               r_s1_valid;
    spd_pkg::t_status   r_s1_status, n_s1_status;
    logic               r_s1_rd_ok, n_s1_rd_ok;
    logic [7:0]         r_s1_dest, r_s1_src, r_s1_msg, r_s1_ref;
    logic [15:0]        r_s1_type;
    logic [9:0]         r_s1_len;

    // output register
    logic               r_out_valid;
    spd_pkg::t_status   r_out_status;
    logic [7:0]         r_out_dest, r_out_src, r_out_msg, r_out_ref, r_out_byte;
    logic [15:0]        r_out_type;
    logic [9:0]         r_out_len;

    logic           w_acc;
    logic           w_s1_adv;
    logic           w_ram_we;
    logic [AW-1:0]  w_ram_waddr;
    logic           w_ram_re;
    logic [AW-1:0]  w_ram_raddr;
    logic [7:0]     w_ram_rdata;
    logic [PW-1:0]  w_rd_pos;
    logic [15:0]    w_total;
    logic [CW-1:0]  w_rem_dec;
    logic [31:0]    w_elapsed_inc;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_s1_valid || w_s1_adv);
    assign w_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = i_rst_n;

    assign w_rd_pos      = PW'(i_payload_index) + PW'(spd_pkg::HEADER_BYTES);
    assign w_total       = {r_len_hi, r_len_lo};
    assign w_rem_dec     = r_bytes_remaining - CW'(1);
    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 32'd1;

    always_comb begin
        n_phase           = r_phase;
        n_listening       = r_listening;
        n_bytes_stored    = r_bytes_stored;
        n_bytes_remaining = r_bytes_remaining;
        n_sum             = r_sum;
        n_elapsed         = r_elapsed;
        n_len_lo          = r_len_lo;
        n_len_hi          = r_len_hi;
        n_dest            = r_dest;
        n_src             = r_src;
        n_msg             = r_msg;
        n_ref             = r_ref;
        n_type_lo         = r_type_lo;
        n_type_hi         = r_type_hi;
        n_s1_status       = spd_pkg::ST_NONE;
        n_s1_rd_ok        = 1'b0;
        w_ram_we          = 1'b0;
        w_ram_waddr       = AW'(r_bytes_stored);
        w_ram_re          = 1'b0;
        w_ram_raddr       = AW'(w_rd_pos);

        if (w_acc) begin
            case (i_req_type)
                spd_pkg::REQ_START: begin
                    n_phase           = PH_HUNT;
                    n_bytes_stored    = '0;
                    n_bytes_remaining = '0;
                    n_sum             = '0;
                    n_elapsed         = '0;
                    n_listening       = 1'b1;
                end
                spd_pkg::REQ_BYTE: begin
                    if (r_listening) begin
                        case (r_phase)
                            PH_HUNT: begin
                                if (i_rx_byte == spd_pkg::SYNC_FIRST) begin
                                    w_ram_we    = 1'b1;
                                    w_ram_waddr = AW'(0);
                                    n_sum       = i_rx_byte;
                                    n_phase     = PH_SYNC2;
                                end
                            end
                            PH_SYNC2: begin
                                // a bad second sync byte is not retried as a first one
                                if (i_rx_byte != spd_pkg::SYNC_SECOND) begin
                                    n_phase = PH_HUNT;
                                end else begin
                                    w_ram_we          = 1'b1;
                                    w_ram_waddr       = AW'(1);
                                    n_sum             = r_sum + i_rx_byte;
                                    n_bytes_stored    = CW'(2);
                                    n_bytes_remaining = CW'(spd_pkg::HEADER_BYTES - 2);
                                    n_phase           = PH_HEADER;
                                end
                            end
                            PH_HEADER: begin
                                w_ram_we          = r_bytes_stored < CW'(BUFFER_BYTES);
                                n_bytes_stored    = r_bytes_stored + CW'(1);
                                n_bytes_remaining = w_rem_dec;
                                n_sum             = r_sum + i_rx_byte;
                                if (r_bytes_stored == CW'(spd_pkg::POS_LEN_LO)) begin
                                    n_len_lo = i_rx_byte;
                                end
                                if (r_bytes_stored == CW'(spd_pkg::POS_LEN_HI)) begin
                                    n_len_hi = i_rx_byte;
                                end
                                if (r_bytes_stored == CW'(spd_pkg::POS_DEST)) begin
                                    n_dest = i_rx_byte;
                                end
                                if (r_bytes_stored == CW'(spd_pkg::POS_SRC)) begin
                                    n_src = i_rx_byte;
                                end
                                if (r_bytes_stored == CW'(spd_pkg::POS_MSG)) begin
                                    n_msg = i_rx_byte;
                                end
                                if (r_bytes_stored == CW'(spd_pkg::POS_REF)) begin
                                    n_ref = i_rx_byte;
                                end
                                if (r_bytes_stored == CW'(spd_pkg::POS_TYPE_LO)) begin
                                    n_type_lo = i_rx_byte;
                                end
                                if (r_bytes_stored == CW'(spd_pkg::POS_TYPE_HI)) begin
                                    n_type_hi = i_rx_byte;
                                end
                                if (w_rem_dec == '0) begin
                                    if (w_total < 16'(spd_pkg::MIN_FRAME) ||
                                        w_total > 16'(BUFFER_BYTES)) begin
                                        n_phase = PH_HUNT;
                                    end else if (w_total != 16'(spd_pkg::MIN_FRAME)) begin
                                        n_bytes_remaining =
                                            CW'(w_total - 16'(spd_pkg::MIN_FRAME));
                                        n_phase = PH_PAYLOAD;
                                    end else begin
                                        n_bytes_remaining = CW'(1);
                                        n_phase           = PH_CHECK;
                                    end
                                end
                            end
                            PH_PAYLOAD: begin
                                w_ram_we          = r_bytes_stored < CW'(BUFFER_BYTES);
                                n_bytes_stored    = r_bytes_stored + CW'(1);
                                n_bytes_remaining = w_rem_dec;
                                n_sum             = r_sum + i_rx_byte;
                                if (w_rem_dec == '0) begin
                                    n_bytes_remaining = CW'(1);
                                    n_phase           = PH_CHECK;
                                end
                            end
                            PH_CHECK: begin
                                w_ram_we          = r_bytes_stored < CW'(BUFFER_BYTES);
                                n_bytes_remaining = '0;
                                n_phase           = PH_HUNT;
                                if (r_sum == i_rx_byte) begin
                                    n_listening = 1'b0;
                                    n_s1_status = spd_pkg::ST_GOOD;
                                end
                            end
                            default: begin
                                n_phase = PH_HUNT;
                            end
                        endcase
                    end
                end
                spd_pkg::REQ_TICK: begin
                    if (r_listening) begin
                        n_elapsed = w_elapsed_inc;
                        if (r_timeout != '0 && w_elapsed_inc >= r_timeout) begin
                            n_listening = 1'b0;
                            n_s1_status = spd_pkg::ST_TIMEOUT;
                        end
                    end
                end
                spd_pkg::REQ_READ: begin
                    n_s1_status = spd_pkg::ST_READ;
                    n_s1_rd_ok  = w_rd_pos < PW'(BUFFER_BYTES);
                    w_ram_re    = n_s1_rd_ok;
                end
                default: begin
                    n_s1_status = spd_pkg::ST_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_HUNT;
            r_listening       <= 1'b0;
            r_bytes_stored    <= '0;
            r_bytes_remaining <= '0;
            r_sum             <= '0;
            r_elapsed         <= '0;
            r_timeout         <= '0;
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_phase           <= n_phase;
            r_listening       <= n_listening;
            r_bytes_stored    <= n_bytes_stored;
            r_bytes_remaining <= n_bytes_remaining;
            r_sum             <= n_sum;
            r_elapsed         <= n_elapsed;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_response_timeout_ms;
            end
            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // payload registers
        r_len_lo  <= n_len_lo;
        r_len_hi  <= n_len_hi;
        r_dest    <= n_dest;
        r_src     <= n_src;
        r_msg     <= n_msg;
        r_ref     <= n_ref;
        r_type_lo <= n_type_lo;
        r_type_hi <= n_type_hi;
        if (w_acc) begin
            r_s1_status <= n_s1_status;
            r_s1_rd_ok  <= n_s1_rd_ok;
            if (n_s1_status == spd_pkg::ST_GOOD) begin
                r_s1_dest <= r_dest;
                r_s1_src  <= r_src;
                r_s1_msg  <= r_msg;
                r_s1_ref  <= r_ref;
                r_s1_type <= {r_type_hi, r_type_lo};
                r_s1_len  <= 10'(r_bytes_stored - CW'(spd_pkg::HEADER_BYTES));
            end else begin
                r_s1_dest <= '0;
                r_s1_src  <= '0;
                r_s1_msg  <= '0;
                r_s1_ref  <= '0;
                r_s1_type <= '0;
                r_s1_len  <= '0;
            end
        end
        if (w_s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_dest   <= r_s1_dest;
            r_out_src    <= r_s1_src;
            r_out_msg    <= r_s1_msg;
            r_out_ref    <= r_s1_ref;
            r_out_type   <= r_s1_type;
            r_out_len    <= r_s1_len;
            // RAM data holds while the read sits in the parse stage
            r_out_byte   <= r_s1_rd_ok ? w_ram_rdata : 8'd0;
        end
    end

    spd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (i_rx_byte),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_dest_address     = r_out_dest;
    assign o_src_address      = r_out_src;
    assign o_message_number   = r_out_msg;
    assign o_reference_number = r_out_ref;
    assign o_packet_type      = r_out_type;
    assign o_payload_length   = r_out_len;
    assign o_payload_byte     = r_out_byte;

    // header phase: stored plus remaining always spans the header
    a_header_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |->
            (r_bytes_stored + r_bytes_remaining == CW'(spd_pkg::HEADER_BYTES)))
        else $error("header byte count out of step");

    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_stored < CW'(BUFFER_BYTES))
        else $error("store count beyond buffer");

    a_good_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && n_s1_status == spd_pkg::ST_GOOD) |=> !r_listening)
        else $error("receiver still armed after good packet");

    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_re |=> (r_s1_valid && r_s1_status == spd_pkg::ST_READ && r_s1_rd_ok))
        else $error("store read not tracked by parse stage");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram_we && w_ram_re))
        else $error("store written and read in one cycle");

endmodule
